>>> rtl/fpst_pkg.sv
// Shared types for the Fenwick prefix-sum table: request codes, controller commands and status.
package fpst_pkg;

	// Request codes carried on req_type
	typedef enum logic [1:0] {
		REQ_SET    = 2'd0,
		REQ_RANGE  = 2'd1,
		REQ_SEARCH = 2'd2
	} req_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear;      // zero one entry of both stores
		logic load;       // capture a request transaction
		logic set_delta;  // form the delta and write the plain value
		logic tree_upd;   // add delta to the current tree node, step up
		logic pfx_acc;    // accumulate the current tree node, step down
		logic pfx_second; // start the lower-bound prefix walk
		logic src_cmp;    // search step: compare and advance
		logic src_skip;   // search step beyond the table: halve the step
		logic finish;     // register the result and strobe it
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clr_last;   // clearing pass at its last entry
		logic err;        // request is flagged
		req_t kind;       // captured request code
		logic node_zero;  // walk index reached zero
		logic node_over;  // walk index beyond the table
		logic second;     // lower-bound walk in progress
		logic step_zero;  // search steps exhausted
		logic next_over;  // search candidate beyond the table
	} sts_t;

endpackage

>>> rtl/fpst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fpst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/fpst_ctrl.sv
// Controller state machine for the Fenwick prefix-sum table.
module fpst_ctrl
	import fpst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	typedef enum logic [11:0] {
		ST_CLEAR    = 12'b0000_0000_0001,
		ST_IDLE     = 12'b0000_0000_0010,
		ST_DISPATCH = 12'b0000_0000_0100,
		ST_SET_RD   = 12'b0000_0000_1000,
		ST_SET_WR   = 12'b0000_0001_0000,
		ST_UPD_RD   = 12'b0000_0010_0000,
		ST_UPD_WR   = 12'b0000_0100_0000,
		ST_PFX_RD   = 12'b0000_1000_0000,
		ST_PFX_ACC  = 12'b0001_0000_0000,
		ST_SRC_RD   = 12'b0010_0000_0000,
		ST_SRC_CMP  = 12'b0100_0000_0000,
		ST_DONE     = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	// state register; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.err) begin
					state_d = ST_DONE;
				end else begin
					case (sts.kind)
						REQ_SET:    state_d = ST_SET_RD;
						REQ_RANGE:  state_d = ST_PFX_RD;
						REQ_SEARCH: state_d = ST_SRC_RD;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			// set: read old plain value, then write the new value and form the delta
			ST_SET_RD: state_d = ST_SET_WR;
			ST_SET_WR: begin
				cmd.set_delta = 1'b1;
				state_d       = ST_UPD_RD;
			end
			// update path: read-modify-write per node
			ST_UPD_RD: begin
				if (sts.node_over) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_UPD_WR;
				end
			end
			ST_UPD_WR: begin
				cmd.tree_upd = 1'b1;
				state_d      = ST_UPD_RD;
			end
			// range: walk r+1 adding, then l subtracting
			ST_PFX_RD: begin
				if (sts.node_zero) begin
					if (sts.second) begin
						state_d = ST_DONE;
					end else begin
						cmd.pfx_second = 1'b1;
					end
				end else begin
					state_d = ST_PFX_ACC;
				end
			end
			ST_PFX_ACC: begin
				cmd.pfx_acc = 1'b1;
				state_d     = ST_PFX_RD;
			end
			// search: binary descent over power-of-two steps
			ST_SRC_RD: begin
				if (sts.step_zero) begin
					state_d = ST_DONE;
				end else if (sts.next_over) begin
					cmd.src_skip = 1'b1;
				end else begin
					state_d = ST_SRC_CMP;
				end
			end
			ST_SRC_CMP: begin
				cmd.src_cmp = 1'b1;
				state_d     = ST_SRC_RD;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/fpst_dp.sv
// Datapath for the Fenwick prefix-sum table: request registers, walk indexes and both stores.
module fpst_dp
	import fpst_pkg::*;
#(
	parameter int SIZE       = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [1:0]         req_type,
	input  logic [9:0]         index_a,
	input  logic [9:0]         index_b,
	input  logic signed [31:0] new_value,
	input  logic signed [31:0] target,
	output logic               done,
	output logic signed [31:0] sum_out,
	output logic [10:0]        found_pos,
	output logic               status
);

	localparam int NB = $clog2(SIZE + 1);          // holds 0..SIZE
	localparam int NW = NB + 1;                    // holds node + lowbit
	localparam int AW = $clog2(SIZE);              // store address
	localparam int CW = (NW > 11) ? NW : 11;       // range-check width
	localparam logic [NB-1:0] TOP_STEP = {1'b1, {(NB-1){1'b0}}};

	// request registers
	req_t                  kind_q;
	logic [9:0]            ia_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] goal_q;
	logic                  err_q;
	// walk registers
	logic [VALUE_BITS-1:0] delta_q;
	logic [NW-1:0]         node_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  sub_q;
	logic [NB-1:0]         pos_q;
	logic [VALUE_BITS-1:0] run_q;
	logic [NB-1:0]         step_q;
	logic [AW-1:0]         clr_q;
	// result registers
	logic                  done_q;
	logic [31:0]           sum_q;
	logic [10:0]           fpos_q;
	logic                  stat_q;

	logic                  err_w;
	logic [NW-1:0]         next_w;
	logic [NW-1:0]         lowbit_w;
	logic [VALUE_BITS-1:0] trial_w;
	logic [10:0]           ia_inc_w;
	logic [10:0]           ib_inc_w;

	logic                  tree_we, plain_we;
	logic [AW-1:0]         tree_waddr, tree_raddr, plain_waddr, plain_raddr;
	logic [VALUE_BITS-1:0] tree_wdata, tree_rdata, plain_wdata, plain_rdata;

	// request check on the incoming transaction
	always_comb begin
		case (req_type)
			REQ_SET:    err_w = (CW'(index_a) >= CW'(SIZE));
			REQ_RANGE:  err_w = (CW'(index_b) >= CW'(SIZE)) || (index_a > index_b);
			REQ_SEARCH: err_w = 1'b0;
			default:    err_w = 1'b1;
		endcase
	end

	assign ia_inc_w = {1'b0, index_a} + 11'd1;
	assign ib_inc_w = {1'b0, index_b} + 11'd1;
	assign next_w   = NW'(pos_q) + NW'(step_q);
	assign lowbit_w = node_q & (~node_q + NW'(1));
	assign trial_w  = run_q + tree_rdata;

	// store ports
	assign tree_we     = cmd.clear | cmd.tree_upd;
	assign tree_waddr  = cmd.clear ? clr_q : AW'(node_q - NW'(1));
	assign tree_wdata  = cmd.clear ? '0 : (tree_rdata + delta_q);
	assign tree_raddr  = (kind_q == REQ_SEARCH) ? AW'(next_w - NW'(1))
	                                            : AW'(node_q - NW'(1));
	assign plain_we    = cmd.clear | cmd.set_delta;
	assign plain_waddr = cmd.clear ? clr_q : AW'(ia_q);
	assign plain_wdata = cmd.clear ? '0 : val_q;
	assign plain_raddr = AW'(ia_q);

	fpst_ram #(.WIDTH(VALUE_BITS), .DEPTH(SIZE)) u_tree (
		.clk   (clk),
		.we    (tree_we),
		.waddr (tree_waddr),
		.wdata (tree_wdata),
		.raddr (tree_raddr),
		.rdata (tree_rdata)
	);

	fpst_ram #(.WIDTH(VALUE_BITS), .DEPTH(SIZE)) u_plain (
		.clk   (clk),
		.we    (plain_we),
		.waddr (plain_waddr),
		.wdata (plain_wdata),
		.raddr (plain_raddr),
		.rdata (plain_rdata)
	);

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= AW'(clr_q + AW'(1));
		end
	end

	// request capture and walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req_t'(req_type);
			ia_q   <= index_a;
			val_q  <= VALUE_BITS'(new_value);
			goal_q <= VALUE_BITS'(target);
			err_q  <= err_w;
			acc_q  <= '0;
			sub_q  <= 1'b0;
			pos_q  <= '0;
			run_q  <= '0;
			step_q <= TOP_STEP;
			node_q <= (req_type == REQ_RANGE) ? NW'(ib_inc_w) : NW'(ia_inc_w);
		end
		if (cmd.set_delta) begin
			delta_q <= val_q - plain_rdata;
		end
		if (cmd.tree_upd) begin
			node_q <= node_q + lowbit_w;
		end
		if (cmd.pfx_second) begin
			node_q <= NW'(ia_q);
			sub_q  <= 1'b1;
		end
		if (cmd.pfx_acc) begin
			acc_q  <= sub_q ? (acc_q - tree_rdata) : (acc_q + tree_rdata);
			node_q <= node_q & (node_q - NW'(1));
		end
		if (cmd.src_cmp) begin
			if ($signed(trial_w) < $signed(goal_q)) begin
				pos_q <= NB'(next_w);
				run_q <= trial_w;
			end
			step_q <= step_q >> 1;
		end
		if (cmd.src_skip) begin
			step_q <= step_q >> 1;
		end
		if (cmd.finish) begin
			sum_q  <= 32'(acc_q);
			fpos_q <= 11'(pos_q);
			stat_q <= err_q;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	// status to the controller
	always_comb begin
		sts.clr_last  = (clr_q == AW'(SIZE - 1));
		sts.err       = err_q;
		sts.kind      = kind_q;
		sts.node_zero = (node_q == '0);
		sts.node_over = (node_q > NW'(SIZE));
		sts.second    = sub_q;
		sts.step_zero = (step_q == '0);
		sts.next_over = (next_w > NW'(SIZE));
	end

	assign done      = done_q;
	assign sum_out   = sum_q;
	assign found_pos = fpos_q;
	assign status    = stat_q;

endmodule

>>> rtl/fenwick_prefix_sum_table_core.sv
// Top level of the Fenwick prefix-sum table: controller, datapath and checks.
//
// Usage: raise start with req_type and its operands while busy is low; the
// transaction is taken at that clock edge. Requests: set a value at index_a,
// sum positions index_a..index_b inclusive, or search for the first position
// whose prefix sum reaches target (SIZE when none does). Exactly one result
// per request appears on sum_out, found_pos and status for one cycle with
// done high; the receiver cannot stall it and must take it then.
// Steps from start to done:
//   set:    read the plain entry, write it, then update each node on the path
//   range:  read and accumulate each node of the r+1 walk, then of the l walk
//   search: per step read the candidate node and compare, or skip it if beyond
//   flagged request: straight from dispatch to done
// Each tree node takes a read and then an accumulate or write on the single
// registered read port of the tree store; one request is in flight at a time.
// After reset the block clears both stores, one entry per cycle, so busy
// stays high until that pass ends and only then is a transaction taken.
module fenwick_prefix_sum_table_core
	import fpst_pkg::*;
#(
	parameter int SIZE       = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [9:0]         index_a,
	input  logic [9:0]         index_b,
	input  logic signed [31:0] new_value,
	input  logic signed [31:0] target,
	output logic               done,
	output logic signed [31:0] sum_out,
	output logic [10:0]        found_pos,
	output logic               status
);

	cmd_t cmd;
	sts_t sts;

	fpst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	fpst_dp #(.SIZE(SIZE), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_type  (req_type),
		.index_a   (index_a),
		.index_b   (index_b),
		.new_value (new_value),
		.target    (target),
		.done      (done),
		.sum_out   (sum_out),
		.found_pos (found_pos),
		.status    (status)
	);

	// an accepted transaction keeps the block busy in the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// a result only follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// one result per transaction: done is low again after every strobe
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// a flagged request carries no sum and no position
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (sum_out == '0) && (found_pos == '0))
		else $error("flagged result carries data");

endmodule
